/* hdl/lav_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types, constants and latency helpers for the look-at view matrix.
// ----------------------------------------------------------------------------
package lav_pkg;

	// default number of fraction bits of the fixed point format
	localparam int FRAC_BITS_DEF = 16;
	// width of every field on the ports
	localparam int DATA_W        = 32;
	// normalized magnitude width, largest component lands in [2^29, 2^30)
	localparam int NORM_MAG_W    = 30;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_UP_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UP_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UP_Z = 2'd2;

	typedef struct packed {
		logic signed [DATA_W-1:0] eye_x;
		logic signed [DATA_W-1:0] eye_y;
		logic signed [DATA_W-1:0] eye_z;
		logic signed [DATA_W-1:0] target_x;
		logic signed [DATA_W-1:0] target_y;
		logic signed [DATA_W-1:0] target_z;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] right_x;
		logic signed [DATA_W-1:0] right_y;
		logic signed [DATA_W-1:0] right_z;
		logic signed [DATA_W-1:0] upv_x;
		logic signed [DATA_W-1:0] upv_y;
		logic signed [DATA_W-1:0] upv_z;
		logic signed [DATA_W-1:0] dir_x;
		logic signed [DATA_W-1:0] dir_y;
		logic signed [DATA_W-1:0] dir_z;
		logic signed [DATA_W-1:0] trans_x;
		logic signed [DATA_W-1:0] trans_y;
		logic signed [DATA_W-1:0] trans_z;
	} out_item_t;

	// normalize unit: six front stages, one stage per root bit, one
	// numerator stage, one stage per quotient bit, one sign stage
	function automatic int norm_lat(input int frac);
		return 6 + (NORM_MAG_W + 1) + 1 + (frac + 1) + 1;
	endfunction

	localparam int CROSS_LAT = 2;
	localparam int TRANS_LAT = 4;

endpackage

/* hdl/lav_delay.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_delay
// Shift line with enable that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module lav_delay #(
	parameter int W     = 8,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] tap_q [DEPTH];

	// advance the line when the pipeline moves
	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign dout = tap_q[DEPTH-1];

endmodule

/* hdl/lav_cross.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_cross
// Two stage cross product: products registered, then the differences.
// ----------------------------------------------------------------------------
module lav_cross #(
	parameter int AW = 32,
	parameter int BW = 18
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [AW-1:0]   a [3],
	input  logic signed [BW-1:0]   b [3],
	output logic signed [AW+BW:0]  c [3]
);

	localparam int PW = AW + BW;

	logic signed [PW-1:0] prod_s1 [6];
	logic signed [PW:0]   c_s2 [3];

	// six component products
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[0] <= a[1] * b[2];
			prod_s1[1] <= a[2] * b[1];
			prod_s1[2] <= a[2] * b[0];
			prod_s1[3] <= a[0] * b[2];
			prod_s1[4] <= a[0] * b[1];
			prod_s1[5] <= a[1] * b[0];
		end
	end

	// differences
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c_s2[i] <= (PW+1)'(prod_s1[2*i]) - (PW+1)'(prod_s1[2*i+1]);
			end
		end
	end

	assign c = c_s2;

endmodule

/* hdl/lav_norm3.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_norm3
// Pipelined 3-vector normalization: magnitude scaling, sum of squares,
// bit-per-stage square root and bit-per-stage rounded division.
// ----------------------------------------------------------------------------
module lav_norm3 #(
	parameter int IW        = 33,
	parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [IW-1:0]       vec [3],
	output logic signed [FRAC_BITS+1:0] unit [3]
);

	localparam int MW  = lav_pkg::NORM_MAG_W;
	localparam int SQW = 2*MW + 2;
	localparam int RTW = MW + 1;
	localparam int RMW = RTW + 3;
	localparam int SHW = $clog2(IW + 1);
	localparam int NW  = FRAC_BITS + MW + 2;
	localparam int DW  = RTW + 1;
	localparam int QW  = FRAC_BITS + 1;
	localparam int OW  = FRAC_BITS + 2;

	// front stages
	logic [IW-1:0]   mag_s1 [3];
	logic [2:0]      neg_s1;
	logic [IW-1:0]   mag_s2 [3];
	logic [IW-1:0]   max_s2;
	logic [2:0]      neg_s2;
	logic [IW-1:0]   mag_s3 [3];
	logic [SHW-1:0]  sh_s3;
	logic            zero_s3;
	logic [2:0]      neg_s3;
	logic [MW-1:0]   mag_s4 [3];
	logic            zero_s4;
	logic [2:0]      neg_s4;
	logic [2*MW-1:0] sq_s5 [3];
	logic [MW-1:0]   mag_s5 [3];
	logic            zero_s5;
	logic [2:0]      neg_s5;

	// root stages, index 0 is the sum stage
	logic [SQW-1:0]  rad_sx  [RTW+1];
	logic [RMW-1:0]  rem_sx  [RTW+1];
	logic [RTW-1:0]  root_sx [RTW+1];
	logic [MW-1:0]   rmag_sx [RTW+1][3];
	logic            rzero_sx [RTW+1];
	logic [2:0]      rneg_sx [RTW+1];

	// division stages, index 0 is the numerator stage
	logic [NW-1:0]   num_sx  [QW+1][3];
	logic [QW-1:0]   quo_sx  [QW+1][3];
	logic [DW-1:0]   den_sx  [QW+1];
	logic            dzero_sx [QW+1];
	logic [2:0]      dneg_sx [QW+1];

	logic signed [OW-1:0] res_sn [3];

	logic [IW-1:0]   mx;
	logic [SHW-1:0]  msb;

	// magnitudes and signs
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vec[i][IW-1];
				mag_s1[i] <= vec[i][IW-1] ? IW'(-vec[i]) : IW'(vec[i]);
			end
		end
	end

	// largest magnitude
	always_comb begin
		mx = mag_s1[0];
		if (mag_s1[1] > mx) mx = mag_s1[1];
		if (mag_s1[2] > mx) mx = mag_s1[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2 <= mag_s1;
			max_s2 <= mx;
			neg_s2 <= neg_s1;
		end
	end

	// leading one of the largest magnitude
	always_comb begin
		msb = '0;
		for (int k = 0; k < IW; k++) begin
			if (max_s2[k]) msb = SHW'(k);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s3  <= mag_s2;
			sh_s3   <= msb + SHW'(1);
			zero_s3 <= (max_s2 == '0);
			neg_s3  <= neg_s2;
		end
	end

	// scale so the largest lies in [2^29, 2^30), truncating
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s4[i] <= MW'({mag_s3[i], MW'(0)} >> sh_s3);
			end
			zero_s4 <= zero_s3;
			neg_s4  <= neg_s3;
		end
	end

	// squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= mag_s4[i] * mag_s4[i];
			end
			mag_s5  <= mag_s4;
			zero_s5 <= zero_s4;
			neg_s5  <= neg_s4;
		end
	end

	// sum of squares
	always_ff @(posedge clk) begin
		if (en) begin
			rad_sx[0]   <= SQW'(sq_s5[0]) + SQW'(sq_s5[1]) + SQW'(sq_s5[2]);
			rem_sx[0]   <= '0;
			root_sx[0]  <= '0;
			rmag_sx[0]  <= mag_s5;
			rzero_sx[0] <= zero_s5;
			rneg_sx[0]  <= neg_s5;
		end
	end

	// one root bit per stage
	for (genvar j = 0; j < RTW; j++) begin : g_root
		logic [RMW-1:0] rem_c;
		logic [RMW-1:0] trial;
		logic           ge;

		always_comb begin
			rem_c = {rem_sx[j][RMW-3:0], rad_sx[j][SQW-1 -: 2]};
			trial = RMW'({root_sx[j], 2'b01});
			ge    = (rem_c >= trial);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_sx[j+1]   <= {rad_sx[j][SQW-3:0], 2'b00};
				rem_sx[j+1]   <= ge ? rem_c - trial : rem_c;
				root_sx[j+1]  <= {root_sx[j][RTW-2:0], ge};
				rmag_sx[j+1]  <= rmag_sx[j];
				rzero_sx[j+1] <= rzero_sx[j];
				rneg_sx[j+1]  <= rneg_sx[j];
			end
		end
	end

	// numerator m * 2^(F+1) + L and denominator 2L
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num_sx[0][i] <= (NW'(rmag_sx[RTW][i]) << (FRAC_BITS + 1))
					+ NW'(root_sx[RTW]);
				quo_sx[0][i] <= '0;
			end
			den_sx[0]   <= {root_sx[RTW], 1'b0};
			dzero_sx[0] <= rzero_sx[RTW];
			dneg_sx[0]  <= rneg_sx[RTW];
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 1; j <= QW; j++) begin : g_div
		localparam int K = QW - j;
		logic [NW-1:0] sub;
		logic [2:0]    ge;

		always_comb begin
			sub = NW'(den_sx[j-1]) << K;
			for (int i = 0; i < 3; i++) begin
				ge[i] = (num_sx[j-1][i] >= sub);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					num_sx[j][i] <= ge[i] ? num_sx[j-1][i] - sub : num_sx[j-1][i];
					quo_sx[j][i] <= quo_sx[j-1][i] | (QW'(ge[i]) << K);
				end
				den_sx[j]   <= den_sx[j-1];
				dzero_sx[j] <= dzero_sx[j-1];
				dneg_sx[j]  <= dneg_sx[j-1];
			end
		end
	end

	// apply signs, zero vector stays zero
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dzero_sx[QW]) begin
					res_sn[i] <= '0;
				end else if (dneg_sx[QW][i]) begin
					res_sn[i] <= -$signed(OW'(quo_sx[QW][i]));
				end else begin
					res_sn[i] <= $signed(OW'(quo_sx[QW][i]));
				end
			end
		end
	end

	assign unit = res_sn;

endmodule

/* hdl/lav_trans.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_trans
// Translation term: negated axis dot eye, rounded half away from zero to the
// fixed point format and saturated to 32 bits.
// ----------------------------------------------------------------------------
module lav_trans #(
	parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [FRAC_BITS+1:0]        axis [3],
	input  logic signed [lav_pkg::DATA_W-1:0]  eye  [3],
	output logic signed [lav_pkg::DATA_W-1:0]  trans
);

	localparam int DW = lav_pkg::DATA_W;
	localparam int PW = FRAC_BITS + 2 + DW;
	localparam int SW = PW + 2;
	localparam int RW = SW - FRAC_BITS;
	localparam logic [RW-1:0] POS_LIM = RW'(64'd2147483647);
	localparam logic [RW-1:0] NEG_LIM = RW'(64'd2147483648);

	logic signed [PW-1:0] prod_s1 [3];
	logic signed [SW-1:0] sum_s2;
	logic [RW-1:0]        mag_s3;
	logic                 neg_s3;
	logic signed [DW-1:0] res_s4;

	logic [SW-1:0]        abs_sum;
	logic [SW-1:0]        rnd;

	// component products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= axis[i] * eye[i];
			end
		end
	end

	// dot product
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= SW'(prod_s1[0]) + SW'(prod_s1[1]) + SW'(prod_s1[2]);
		end
	end

	// magnitude of the negated sum, rounded half up
	always_comb begin
		abs_sum = sum_s2[SW-1] ? SW'(-sum_s2) : SW'(sum_s2);
		rnd     = abs_sum + (SW'(1) << (FRAC_BITS - 1));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s3 <= rnd[SW-1:FRAC_BITS];
			neg_s3 <= (sum_s2 > 0);
		end
	end

	// sign and saturation
	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s3) begin
				res_s4 <= (mag_s3 > NEG_LIM) ? DW'(NEG_LIM) : -$signed(mag_s3[DW-1:0]);
			end else begin
				res_s4 <= (mag_s3 > POS_LIM) ? DW'(POS_LIM) : $signed(mag_s3[DW-1:0]);
			end
		end
	end

	assign trans = res_s4;

endmodule

/* hdl/look_at_view_matrix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Q16.16 fixed point at the default FRAC_BITS. Throughput: one request per
// cycle while in_stall is low; three chained normalize units, each one
// root bit and one quotient bit per stage, set the depth.
// Reset: world up vector returns to (0, 1.0, 0) and the pipeline empties.
// ----------------------------------------------------------------------------
module look_at_view_matrix #(
	parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  lav_pkg::in_item_t                in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output lav_pkg::out_item_t               out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lav_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lav_pkg::DATA_W-1:0]       cfg_data
);

	localparam int DW  = lav_pkg::DATA_W;
	localparam int NL  = lav_pkg::norm_lat(FRAC_BITS);
	localparam int CL  = lav_pkg::CROSS_LAT;
	localparam int TL  = lav_pkg::TRANS_LAT;
	localparam int UW  = FRAC_BITS + 2;
	localparam int VW  = 3 * UW;
	localparam int RTW = DW + UW + 1;
	localparam int UPW = 2 * UW + 1;
	localparam int T3  = 1 + 3 * NL + 2 * CL;
	localparam int PIPE_LAT = T3 + TL;
	localparam logic signed [DW-1:0] UP_Y_RST = DW'(64'd1 << FRAC_BITS);

	logic signed [DW-1:0] up_q [3];
	logic                 en;
	logic [PIPE_LAT-1:0]  vld_q;
	logic signed [DW:0]   d_s1 [3];
	logic signed [DW-1:0] eye_s1 [3];

	logic signed [UW-1:0]  dir_n [3];
	logic signed [RTW-1:0] rt_c [3];
	logic signed [UW-1:0]  right_n [3];
	logic signed [UW-1:0]  dir_t2 [3];
	logic signed [UPW-1:0] u_c [3];
	logic signed [UW-1:0]  upv_n [3];
	logic signed [UW-1:0]  dir_t3 [3];
	logic signed [UW-1:0]  right_t3 [3];
	logic signed [DW-1:0]  eye_t3 [3];
	logic signed [UW-1:0]  dir_o [3];
	logic signed [UW-1:0]  right_o [3];
	logic signed [UW-1:0]  upv_o [3];
	logic signed [DW-1:0]  tr_o [3];

	logic [VW-1:0]   dir_pk, dir_t2_pk, dir_t3_pk, dir_o_pk;
	logic [VW-1:0]   right_pk, right_t3_pk, right_o_pk;
	logic [VW-1:0]   upv_pk, upv_o_pk;
	logic [3*DW-1:0] eye_pk, eye_t3_pk;

	lav_pkg::out_item_t pipe_dat;
	logic               pipe_take;
	logic               ovld_q;
	lav_pkg::out_item_t odat_q;
	logic               svld_q;
	lav_pkg::out_item_t sdat_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q[0] <= '0;
			up_q[1] <= UP_Y_RST;
			up_q[2] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lav_pkg::CFG_UP_X: up_q[0] <= cfg_data;
				lav_pkg::CFG_UP_Y: up_q[1] <= cfg_data;
				lav_pkg::CFG_UP_Z: up_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline moves while the skid stage is empty
	assign en       = !svld_q;
	assign in_stall = svld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], in_valid};
		end
	end

	// eye minus target
	always_ff @(posedge clk) begin
		if (en) begin
			eye_s1[0] <= in_data.eye_x;
			eye_s1[1] <= in_data.eye_y;
			eye_s1[2] <= in_data.eye_z;
			d_s1[0]   <= (DW+1)'(in_data.eye_x) - (DW+1)'(in_data.target_x);
			d_s1[1]   <= (DW+1)'(in_data.eye_y) - (DW+1)'(in_data.target_y);
			d_s1[2]   <= (DW+1)'(in_data.eye_z) - (DW+1)'(in_data.target_z);
		end
	end

	// direction, right and camera up chain
	lav_norm3 #(.IW(DW + 1), .FRAC_BITS(FRAC_BITS)) u_norm_dir (
		.clk(clk), .en(en), .vec(d_s1), .unit(dir_n)
	);

	lav_cross #(.AW(DW), .BW(UW)) u_cross_right (
		.clk(clk), .en(en), .a(up_q), .b(dir_n), .c(rt_c)
	);

	lav_norm3 #(.IW(RTW), .FRAC_BITS(FRAC_BITS)) u_norm_right (
		.clk(clk), .en(en), .vec(rt_c), .unit(right_n)
	);

	lav_cross #(.AW(UW), .BW(UW)) u_cross_up (
		.clk(clk), .en(en), .a(dir_t2), .b(right_n), .c(u_c)
	);

	lav_norm3 #(.IW(UPW), .FRAC_BITS(FRAC_BITS)) u_norm_up (
		.clk(clk), .en(en), .vec(u_c), .unit(upv_n)
	);

	// pack and unpack vectors around the delay lines
	assign dir_pk   = {dir_n[0], dir_n[1], dir_n[2]};
	assign right_pk = {right_n[0], right_n[1], right_n[2]};
	assign upv_pk   = {upv_n[0], upv_n[1], upv_n[2]};
	assign eye_pk   = {eye_s1[0], eye_s1[1], eye_s1[2]};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dir_t2[i]   = dir_t2_pk[VW-1-i*UW -: UW];
			dir_t3[i]   = dir_t3_pk[VW-1-i*UW -: UW];
			right_t3[i] = right_t3_pk[VW-1-i*UW -: UW];
			dir_o[i]    = dir_o_pk[VW-1-i*UW -: UW];
			right_o[i]  = right_o_pk[VW-1-i*UW -: UW];
			upv_o[i]    = upv_o_pk[VW-1-i*UW -: UW];
			eye_t3[i]   = eye_t3_pk[3*DW-1-i*DW -: DW];
		end
	end

	lav_delay #(.W(VW), .DEPTH(CL + NL)) u_dly_dir_a (
		.clk(clk), .en(en), .din(dir_pk), .dout(dir_t2_pk)
	);

	lav_delay #(.W(VW), .DEPTH(CL + NL)) u_dly_dir_b (
		.clk(clk), .en(en), .din(dir_t2_pk), .dout(dir_t3_pk)
	);

	lav_delay #(.W(VW), .DEPTH(TL)) u_dly_dir_c (
		.clk(clk), .en(en), .din(dir_t3_pk), .dout(dir_o_pk)
	);

	lav_delay #(.W(VW), .DEPTH(CL + NL)) u_dly_right_a (
		.clk(clk), .en(en), .din(right_pk), .dout(right_t3_pk)
	);

	lav_delay #(.W(VW), .DEPTH(TL)) u_dly_right_b (
		.clk(clk), .en(en), .din(right_t3_pk), .dout(right_o_pk)
	);

	lav_delay #(.W(VW), .DEPTH(TL)) u_dly_up (
		.clk(clk), .en(en), .din(upv_pk), .dout(upv_o_pk)
	);

	lav_delay #(.W(3 * DW), .DEPTH(T3 - 1)) u_dly_eye (
		.clk(clk), .en(en), .din(eye_pk), .dout(eye_t3_pk)
	);

	// translations
	lav_trans #(.FRAC_BITS(FRAC_BITS)) u_trans_x (
		.clk(clk), .en(en), .axis(right_t3), .eye(eye_t3), .trans(tr_o[0])
	);

	lav_trans #(.FRAC_BITS(FRAC_BITS)) u_trans_y (
		.clk(clk), .en(en), .axis(upv_n), .eye(eye_t3), .trans(tr_o[1])
	);

	lav_trans #(.FRAC_BITS(FRAC_BITS)) u_trans_z (
		.clk(clk), .en(en), .axis(dir_t3), .eye(eye_t3), .trans(tr_o[2])
	);

	// result assembly
	always_comb begin
		pipe_dat.right_x = DW'(right_o[0]);
		pipe_dat.right_y = DW'(right_o[1]);
		pipe_dat.right_z = DW'(right_o[2]);
		pipe_dat.upv_x   = DW'(upv_o[0]);
		pipe_dat.upv_y   = DW'(upv_o[1]);
		pipe_dat.upv_z   = DW'(upv_o[2]);
		pipe_dat.dir_x   = DW'(dir_o[0]);
		pipe_dat.dir_y   = DW'(dir_o[1]);
		pipe_dat.dir_z   = DW'(dir_o[2]);
		pipe_dat.trans_x = tr_o[0];
		pipe_dat.trans_y = tr_o[1];
		pipe_dat.trans_z = tr_o[2];
	end

	assign pipe_take = en && vld_q[PIPE_LAT-1];

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
			svld_q <= 1'b0;
		end else if (!ovld_q || !out_stall) begin
			if (svld_q) begin
				ovld_q <= 1'b1;
				svld_q <= 1'b0;
			end else begin
				ovld_q <= pipe_take;
			end
		end else if (pipe_take) begin
			svld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ovld_q || !out_stall) begin
			odat_q <= svld_q ? sdat_q : pipe_dat;
		end else if (pipe_take) begin
			sdat_q <= pipe_dat;
		end
	end

	assign out_valid = ovld_q;
	assign out_data  = odat_q;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives camera requests into look_at_view_matrix under several world up
// vectors, predicts every basis and translation field in fixed point and
// compares each result with the oldest prediction, with random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;

	localparam int FB = lav_pkg::FRAC_BITS_DEF;
	localparam longint ONE = longint'(1) << FB;
	// index 3 maps to no register, a write there is dropped
	localparam logic [lav_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int LAT = 3 * (FB + 40) + 10;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	lav_pkg::in_item_t in_data;
	logic out_valid;
	logic out_stall;
	lav_pkg::out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [lav_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [lav_pkg::DATA_W-1:0] cfg_data;

	longint world_up [3];
	lav_pkg::out_item_t matrix_q [$];
	int errors = 0;

	// directed stimulus rows
	typedef struct {
		lav_pkg::in_item_t req;
		bit typed;
		lav_pkg::out_item_t res;
	} row_t;
	row_t rows [$];

	look_at_view_matrix uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

	// integer square root, floor
	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// scale to unit length, rounding half up
	function automatic void unit_vec(input longint v [3], output longint o [3]);
		longint unsigned mag [3];
		longint unsigned mx;
		longint unsigned sum;
		longint unsigned len;
		longint unsigned q;
		mx = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
			if (mag[i] > mx) mx = mag[i];
		end
		if (mx == 0) begin
			o = '{0, 0, 0};
			return;
		end
		while (mx >= (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++) mag[i] >>= 1;
			mx >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			for (int i = 0; i < 3; i++) mag[i] <<= 1;
			mx <<= 1;
		end
		for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((mag[i] << (FB + 1)) + len) / (2 * len);
			o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
	endfunction

	function automatic void cross_prod(input longint a [3], input longint b [3],
			output longint o [3]);
		o[0] = a[1] * b[2] - a[2] * b[1];
		o[1] = a[2] * b[0] - a[0] * b[2];
		o[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	// negated dot product, rounded away from zero on ties, saturated
	function automatic logic [31:0] offset_of(input longint ax [3], input longint eye [3]);
		longint s;
		longint unsigned m;
		longint r;
		s = -(ax[0] * eye[0] + ax[1] * eye[1] + ax[2] * eye[2]);
		m = s < 0 ? longint'(-s) : longint'(s);
		m = (m + (64'd1 << (FB - 1))) >> FB;
		r = s < 0 ? -longint'(m) : longint'(m);
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r[31:0];
	endfunction

	function automatic lav_pkg::out_item_t view_matrix(input lav_pkg::in_item_t r);
		longint eye [3];
		longint d [3];
		longint dir [3];
		longint rt [3];
		longint right [3];
		longint u [3];
		longint upv [3];
		lav_pkg::out_item_t m;
		eye = '{longint'(r.eye_x), longint'(r.eye_y), longint'(r.eye_z)};
		d[0] = eye[0] - longint'(r.target_x);
		d[1] = eye[1] - longint'(r.target_y);
		d[2] = eye[2] - longint'(r.target_z);
		unit_vec(d, dir);
		cross_prod(world_up, dir, rt);
		unit_vec(rt, right);
		cross_prod(dir, right, u);
		unit_vec(u, upv);
		m.right_x = right[0][31:0];
		m.right_y = right[1][31:0];
		m.right_z = right[2][31:0];
		m.upv_x = upv[0][31:0];
		m.upv_y = upv[1][31:0];
		m.upv_z = upv[2][31:0];
		m.dir_x = dir[0][31:0];
		m.dir_y = dir[1][31:0];
		m.dir_z = dir[2][31:0];
		m.trans_x = offset_of(right, eye);
		m.trans_y = offset_of(upv, eye);
		m.trans_z = offset_of(dir, eye);
		return m;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
	endtask

	// no gap half of the time, else mostly short gaps and a few long ones
	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 50) return 0;
		if (p < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// result checker
	always @(posedge clk) begin
		lav_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (matrix_q.size() == 0) begin
				errors++;
				$display("unexpected result at %0t", $realtime);
			end else begin
				want = matrix_q.pop_front();
				if (out_data.right_x !== want.right_x) report("right_x", out_data.right_x, want.right_x);
				if (out_data.right_y !== want.right_y) report("right_y", out_data.right_y, want.right_y);
				if (out_data.right_z !== want.right_z) report("right_z", out_data.right_z, want.right_z);
				if (out_data.upv_x !== want.upv_x) report("upv_x", out_data.upv_x, want.upv_x);
				if (out_data.upv_y !== want.upv_y) report("upv_y", out_data.upv_y, want.upv_y);
				if (out_data.upv_z !== want.upv_z) report("upv_z", out_data.upv_z, want.upv_z);
				if (out_data.dir_x !== want.dir_x) report("dir_x", out_data.dir_x, want.dir_x);
				if (out_data.dir_y !== want.dir_y) report("dir_y", out_data.dir_y, want.dir_y);
				if (out_data.dir_z !== want.dir_z) report("dir_z", out_data.dir_z, want.dir_z);
				if (out_data.trans_x !== want.trans_x) report("trans_x", out_data.trans_x, want.trans_x);
				if (out_data.trans_y !== want.trans_y) report("trans_y", out_data.trans_y, want.trans_y);
				if (out_data.trans_z !== want.trans_z) report("trans_z", out_data.trans_z, want.trans_z);
			end
		end
	end

	// receiver stalls, with stall-free stretches
	initial begin
		int quiet;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			quiet = $urandom_range(99) < 30;
			repeat ($urandom_range(20, 80)) begin
				if (!quiet && $urandom_range(99) == 0) begin
					out_stall <= 1'b1;
					repeat ($urandom_range(20, 60)) @(negedge clk);
				end else begin
					out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 25);
				end
				@(negedge clk);
			end
		end
	end

	task automatic write_reg(input logic [lav_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == lav_pkg::CFG_UP_X) world_up[0] = longint'(signed'(val));
		else if (idx == lav_pkg::CFG_UP_Y) world_up[1] = longint'(signed'(val));
		else if (idx == lav_pkg::CFG_UP_Z) world_up[2] = longint'(signed'(val));
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_up(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		write_reg(lav_pkg::CFG_UP_X, x);
		write_reg(lav_pkg::CFG_UP_Y, y);
		write_reg(lav_pkg::CFG_UP_Z, z);
	endtask

	// called at a falling edge, returns at a falling edge after acceptance
	task automatic send_request(input lav_pkg::in_item_t r, input bit typed,
			input lav_pkg::out_item_t res);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (in_stall);
		matrix_q.push_back(typed ? res : view_matrix(r));
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (matrix_q.size() != 0) @(negedge clk);
		repeat (LAT + 20) @(negedge clk);
	endtask

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(4))
			0: return $urandom;
			1: return $urandom >>> $urandom_range(31);
			2: return 32'(signed'($urandom_range(0, 8 * ONE)) - 4 * ONE);
			3: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
			default: return $urandom & 32'hFFFF0000;
		endcase
	endfunction

	function automatic lav_pkg::in_item_t rnd_request();
		lav_pkg::in_item_t r;
		int k;
		r = {rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word()};
		k = $urandom_range(9);
		// eye on the target
		if (k == 0) begin
			r.target_x = r.eye_x;
			r.target_y = r.eye_y;
			r.target_z = r.eye_z;
		end
		// view axis along the world up vector
		if (k == 1) begin
			r.target_x = r.eye_x - 32'(world_up[0] >>> 4);
			r.target_y = r.eye_y - 32'(world_up[1] >>> 4);
			r.target_z = r.eye_z - 32'(world_up[2] >>> 4);
		end
		return r;
	endfunction

	function automatic row_t mk(input logic [31:0] ex, ey, ez, tx, ty, tz);
		row_t w;
		w.req = {ex, ey, ez, tx, ty, tz};
		w.typed = 1'b0;
		w.res = '0;
		return w;
	endfunction

	initial begin
		row_t w;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = lav_pkg::CFG_UP_X;
		cfg_data = '0;
		world_up = '{0, ONE, 0};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// eye on target gives an all-zero matrix
		w = mk(0, 0, 0, 0, 0, 0);
		w.typed = 1'b1;
		rows.push_back(w);
		w = mk(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
		w.typed = 1'b1;
		rows.push_back(w);
		// looking straight down the up axis: only dir and trans_z survive
		w = mk(0, 32'(3 * ONE), 0, 0, 0, 0);
		w.typed = 1'b1;
		w.res.dir_y = 32'(ONE);
		w.res.trans_z = 32'(-3 * ONE);
		rows.push_back(w);
		rows.push_back(mk(0, 0, 32'(5 * ONE), 0, 0, 0));
		rows.push_back(mk(32'(ONE), 32'(ONE), 32'(ONE), 0, 0, 0));
		rows.push_back(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h80000000, 32'h80000000));
		rows.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
		rows.push_back(mk(32'h7FFFFFFF, 0, 32'h80000000, 0, 0, 0));
		rows.push_back(mk(1, 0, 0, 0, 0, 0));
		rows.push_back(mk(1, 1, 1, 0, 0, 0));
		rows.push_back(mk(0, 0, 1, 0, 0, 0));
		rows.push_back(mk(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0));
		rows.push_back(mk(32'h80000000, 32'h7FFFFFFF, 1, 32'h7FFFFFFF, 0, 32'hFFFFFFFF));
		rows.push_back(mk(32'h00010000, 32'hFFFF0000, 32'h00008000, 0, 0, 0));
		rows.push_back(mk(32'h55555555, 32'hAAAAAAAA, 32'h12345678,
			32'hAAAAAAAA, 32'h55555555, 32'hEDCBA988));
		foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].res);
		drain();

		// a write to an unmapped index is dropped
		write_reg(CFG_UNUSED, 32'hDEADBEEF);
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_up(0, 32'(ONE), 0);
				1: set_up(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
				2: set_up(32'h80000000, 0, 0);
				3: set_up(0, 0, 0);
				4: set_up(32'(ONE), 32'(ONE), 32'h80000000);
				default: set_up($urandom, $urandom, $urandom);
			endcase
			repeat (72) send_request(rnd_request(), 1'b0, '0);
			drain();
		end

		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* look_at_view_matrix.f */
hdl/lav_pkg.sv
hdl/lav_delay.sv
hdl/lav_cross.sv
hdl/lav_norm3.sv
hdl/lav_trans.sv
hdl/look_at_view_matrix.sv
tb/sv/testbench.sv
